[rtl/gsp_pkg.sv]
// ----------------------------------------------------------------------------
// gsp_pkg
// Types, widths, constant tables and threshold helper for the gas sensor
// ppm converter.
// ----------------------------------------------------------------------------
`default_nettype none

package gsp_pkg;

  localparam int TEMP_W   = 10;
  localparam int GAS_W    = 10;
  localparam int TENTHS_W = 12;
  localparam int WHOLE_W  = 8;
  localparam int LEVEL_W  = 5;
  localparam int PPM_W    = 14;
  localparam int HUND_W   = 7;

  localparam int RATIO_FRAC_BITS_DEF = 16;
  localparam int COMP_ENTRIES        = 13;
  localparam int IDX_W               = 4;
  localparam int LEVELS              = 18;

  // numerator 4000 - 2*gas and denominator 9*gas
  localparam int NUM_W     = 12;
  localparam int DEN_W     = 14;
  localparam int NUM_BASE  = 4000;

  // temp / 20 as (temp * 3277) >> 16, exact over the 10-bit range
  localparam int RECIP20       = 3277;
  localparam int RECIP_SHIFT   = 16;
  localparam int RECIP_PROD_W  = 22;
  localparam int IDX_RAW_W     = RECIP_PROD_W - RECIP_SHIFT;
  localparam int IDX_OFFSET    = 2;

  localparam logic [7:0] COMP_HUNDREDTHS [COMP_ENTRIES] = '{
    8'd132, 8'd125, 8'd118, 8'd110, 8'd105, 8'd102, 8'd100,
    8'd98, 8'd97, 8'd95, 8'd92, 8'd91, 8'd90
  };

  localparam logic [7:0] BAND_LIMIT [LEVELS-1] = '{
    8'd200, 8'd170, 8'd140, 8'd130, 8'd120, 8'd115, 8'd112, 8'd106, 8'd100,
    8'd74, 8'd64, 8'd57, 8'd52, 8'd47, 8'd45, 8'd42, 8'd41
  };

  localparam logic [PPM_W-1:0] BAND_PPM [LEVELS] = '{
    14'd200, 14'd300, 14'd400, 14'd500, 14'd600, 14'd700, 14'd800, 14'd900,
    14'd1000, 14'd2000, 14'd3000, 14'd4000, 14'd5000, 14'd6000, 14'd7000,
    14'd8000, 14'd9000, 14'd10000
  };

  localparam logic [HUND_W-1:0] BAND_HUND [LEVELS] = '{
    7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd8, 7'd9, 7'd10,
    7'd20, 7'd30, 7'd40, 7'd50, 7'd60, 7'd70, 7'd80, 7'd90, 7'd100
  };

  typedef struct packed {
    logic [TENTHS_W-1:0] tenths;
    logic [WHOLE_W-1:0]  whole;
    logic [IDX_W-1:0]    idx;
    logic                clamped;
    logic                zero;
  } side_t;

  // Smallest raw ratio q with floor(floor(q*100/f)*100) >= limit * 2^frac.
  // c >= ceil(limit*2^frac/100) = k, and c >= k iff q >= ceil(k*f/100).
  function automatic longint unsigned thr_q(input int ci, input int lvl,
                                            input int frac);
    longint unsigned k;
    longint unsigned m;
    k = ((longint'(BAND_LIMIT[lvl]) << frac) + 99) / 100;
    m = (k * longint'(COMP_HUNDREDTHS[ci]) + 99) / 100;
    return m;
  endfunction

endpackage

`default_nettype wire

[rtl/gsp_prep.sv]
// ----------------------------------------------------------------------------
// gsp_prep
// Input stage: temperature scaling, compensation index, divider operands.
// ----------------------------------------------------------------------------
`default_nettype none

module gsp_prep (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic [gsp_pkg::TEMP_W-1:0]  temp_sample,
  input  wire logic [gsp_pkg::GAS_W-1:0]   gas_sample,
  output logic                             out_valid,
  output gsp_pkg::side_t                   out_side,
  output logic [gsp_pkg::NUM_W-1:0]        out_num,
  output logic [gsp_pkg::DEN_W-1:0]        out_den
);

  logic [gsp_pkg::RECIP_PROD_W-1:0] recip_prod;
  logic [gsp_pkg::IDX_RAW_W:0]      idx_sum;
  logic [gsp_pkg::TENTHS_W:0]       times5;
  gsp_pkg::side_t                   side_next;
  logic [gsp_pkg::NUM_W-1:0]        num_next;
  logic [gsp_pkg::DEN_W-1:0]        den_next;

  always_comb begin
    recip_prod = gsp_pkg::RECIP_PROD_W'(temp_sample)
               * gsp_pkg::RECIP_PROD_W'(gsp_pkg::RECIP20);
    idx_sum = (gsp_pkg::IDX_RAW_W+1)'(recip_prod[gsp_pkg::RECIP_PROD_W-1:gsp_pkg::RECIP_SHIFT])
            + (gsp_pkg::IDX_RAW_W+1)'(gsp_pkg::IDX_OFFSET);
    times5 = ((gsp_pkg::TENTHS_W+1)'(temp_sample) << 2)
           + (gsp_pkg::TENTHS_W+1)'(temp_sample);

    side_next.tenths = times5[gsp_pkg::TENTHS_W:1];
    // (5t/2)/10 truncated is t/4
    side_next.whole  = temp_sample[gsp_pkg::TEMP_W-1:2];
    if (idx_sum > (gsp_pkg::IDX_RAW_W+1)'(gsp_pkg::COMP_ENTRIES-1)) begin
      side_next.idx     = gsp_pkg::IDX_W'(gsp_pkg::COMP_ENTRIES-1);
      side_next.clamped = 1'b1;
    end else begin
      side_next.idx     = idx_sum[gsp_pkg::IDX_W-1:0];
      side_next.clamped = 1'b0;
    end
    side_next.zero = (gas_sample == '0);

    num_next = gsp_pkg::NUM_W'(gsp_pkg::NUM_BASE) - (gsp_pkg::NUM_W'(gas_sample) << 1);
    den_next = (gsp_pkg::DEN_W'(gas_sample) << 3) + gsp_pkg::DEN_W'(gas_sample);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_side <= side_next;
    out_num  <= num_next;
    out_den  <= den_next;
  end

endmodule

`default_nettype wire

[rtl/gsp_div_stage.sv]
// ----------------------------------------------------------------------------
// gsp_div_stage
// One restoring-division step: one quotient bit of (num << FRAC) / den.
// ----------------------------------------------------------------------------
`default_nettype none

module gsp_div_stage #(
  parameter int FRAC = gsp_pkg::RATIO_FRAC_BITS_DEF,
  parameter int BIT  = 0
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    in_valid,
  input  wire gsp_pkg::side_t                          in_side,
  input  wire logic [gsp_pkg::NUM_W-1:0]               in_num,
  input  wire logic [gsp_pkg::DEN_W-1:0]               in_den,
  input  wire logic [gsp_pkg::DEN_W-1:0]               in_rem,
  input  wire logic [gsp_pkg::NUM_W+FRAC-1:0]          in_quo,
  output logic                                         out_valid,
  output gsp_pkg::side_t                               out_side,
  output logic [gsp_pkg::NUM_W-1:0]                    out_num,
  output logic [gsp_pkg::DEN_W-1:0]                    out_den,
  output logic [gsp_pkg::DEN_W-1:0]                    out_rem,
  output logic [gsp_pkg::NUM_W+FRAC-1:0]               out_quo
);

  localparam int QW = gsp_pkg::NUM_W + FRAC;

  logic                       num_bit;
  logic [gsp_pkg::DEN_W:0]    trial;
  logic [gsp_pkg::DEN_W:0]    diff;
  logic                       q_bit;
  logic [gsp_pkg::DEN_W-1:0]  rem_next;

  if (BIT >= FRAC) begin : g_num_bit
    assign num_bit = in_num[BIT-FRAC];
  end else begin : g_zero_bit
    assign num_bit = 1'b0;
  end

  always_comb begin
    trial    = {in_rem, num_bit};
    diff     = trial - {1'b0, in_den};
    q_bit    = (trial >= {1'b0, in_den});
    rem_next = q_bit ? diff[gsp_pkg::DEN_W-1:0] : trial[gsp_pkg::DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_side <= in_side;
    out_num  <= in_num;
    out_den  <= in_den;
    out_rem  <= rem_next;
    out_quo  <= {in_quo[QW-2:0], q_bit};
  end

endmodule

`default_nettype wire

[rtl/gsp_band.sv]
// ----------------------------------------------------------------------------
// gsp_band
// Compensated threshold compare, band encode and ppm lookup; output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gsp_band #(
  parameter int FRAC = gsp_pkg::RATIO_FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  input  wire gsp_pkg::side_t                      in_side,
  input  wire logic [gsp_pkg::NUM_W+FRAC-1:0]      in_quo,
  output logic                                     done,
  output logic [gsp_pkg::TENTHS_W-1:0]             temp_tenths,
  output logic [gsp_pkg::WHOLE_W-1:0]              temp_whole,
  output logic [gsp_pkg::LEVEL_W-1:0]              level_index,
  output logic [gsp_pkg::PPM_W-1:0]                gas_ppm,
  output logic [gsp_pkg::HUND_W-1:0]               gas_hundreds,
  output logic                                     index_clamped
);

  localparam int QW    = gsp_pkg::NUM_W + FRAC;
  localparam int NTHR  = gsp_pkg::LEVELS - 1;
  localparam int NIDX  = 2 ** gsp_pkg::IDX_W;

  logic [QW-1:0]               thr_tab [NIDX][NTHR];
  logic [NTHR-1:0]             hit_next;
  logic [NTHR-1:0]             hit;
  logic                        hit_valid;
  gsp_pkg::side_t              hit_side;
  logic [gsp_pkg::LEVEL_W-1:0] level_next;

  for (genvar gi = 0; gi < NIDX; gi++) begin : g_idx
    for (genvar gl = 0; gl < NTHR; gl++) begin : g_lvl
      localparam int CI = (gi < gsp_pkg::COMP_ENTRIES) ? gi : gsp_pkg::COMP_ENTRIES - 1;
      localparam longint unsigned TV = gsp_pkg::thr_q(CI, gl, FRAC);
      assign thr_tab[gi][gl] = TV[QW-1:0];
    end
  end

  always_comb begin
    for (int l = 0; l < NTHR; l++) begin
      hit_next[l] = in_side.zero | (in_quo >= thr_tab[in_side.idx][l]);
    end
  end

  always_comb begin
    level_next = gsp_pkg::LEVEL_W'(NTHR);
    for (int l = NTHR - 1; l >= 0; l--) begin
      if (hit[l]) begin
        level_next = gsp_pkg::LEVEL_W'(l);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      hit_valid <= in_valid;
      done      <= hit_valid;
    end
  end

  always_ff @(posedge clk) begin
    hit           <= hit_next;
    hit_side      <= in_side;
    temp_tenths   <= hit_side.tenths;
    temp_whole    <= hit_side.whole;
    index_clamped <= hit_side.clamped;
    level_index   <= level_next;
    gas_ppm       <= gsp_pkg::BAND_PPM[level_next];
    gas_hundreds  <= gsp_pkg::BAND_HUND[level_next];
  end

endmodule

`default_nettype wire

[rtl/gas_sensor_ppm_converter.sv]
// ----------------------------------------------------------------------------
// gas_sensor_ppm_converter
// Converts a temperature and a gas sample pair into temperature readings and
// a temperature-compensated gas concentration band.
// ----------------------------------------------------------------------------
//  channel   ports                                      handshake
//  input     temp_sample, gas_sample                    start && !busy
//  result    temp_tenths, temp_whole, level_index,      done, one cycle
//            gas_ppm, gas_hundreds, index_clamped
//
//  One beat per cycle in, one result per cycle out, in order.
//  The pipeline is one input stage, one restoring divider stage per
//  quotient bit (RATIO_FRAC_BITS + 12), compare, output.
//  busy is always low. The receiver cannot stall, so nothing stalls.
//  rst clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module gas_sensor_ppm_converter #(
  parameter int RATIO_FRAC_BITS = gsp_pkg::RATIO_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [gsp_pkg::TEMP_W-1:0]    temp_sample,
  input  wire logic [gsp_pkg::GAS_W-1:0]     gas_sample,
  output logic                               done,
  output logic [gsp_pkg::TENTHS_W-1:0]       temp_tenths,
  output logic [gsp_pkg::WHOLE_W-1:0]        temp_whole,
  output logic [gsp_pkg::LEVEL_W-1:0]        level_index,
  output logic [gsp_pkg::PPM_W-1:0]          gas_ppm,
  output logic [gsp_pkg::HUND_W-1:0]         gas_hundreds,
  output logic                               index_clamped
);

  localparam int QW = gsp_pkg::NUM_W + RATIO_FRAC_BITS;

  logic                        v   [QW+1];
  gsp_pkg::side_t              sd  [QW+1];
  logic [gsp_pkg::NUM_W-1:0]   num [QW+1];
  logic [gsp_pkg::DEN_W-1:0]   den [QW+1];
  logic [gsp_pkg::DEN_W-1:0]   rem [QW+1];
  logic [QW-1:0]               quo [QW+1];

  assign busy = 1'b0;

  gsp_prep u_prep (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (start && !busy),
    .temp_sample (temp_sample),
    .gas_sample  (gas_sample),
    .out_valid   (v[0]),
    .out_side    (sd[0]),
    .out_num     (num[0]),
    .out_den     (den[0])
  );

  assign rem[0] = '0;
  assign quo[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_div
    gsp_div_stage #(
      .FRAC (RATIO_FRAC_BITS),
      .BIT  (QW - 1 - k)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v[k]),
      .in_side   (sd[k]),
      .in_num    (num[k]),
      .in_den    (den[k]),
      .in_rem    (rem[k]),
      .in_quo    (quo[k]),
      .out_valid (v[k+1]),
      .out_side  (sd[k+1]),
      .out_num   (num[k+1]),
      .out_den   (den[k+1]),
      .out_rem   (rem[k+1]),
      .out_quo   (quo[k+1])
    );
  end

  gsp_band #(
    .FRAC (RATIO_FRAC_BITS)
  ) u_band (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (v[QW]),
    .in_side       (sd[QW]),
    .in_quo        (quo[QW]),
    .done          (done),
    .temp_tenths   (temp_tenths),
    .temp_whole    (temp_whole),
    .level_index   (level_index),
    .gas_ppm       (gas_ppm),
    .gas_hundreds  (gas_hundreds),
    .index_clamped (index_clamped)
  );

endmodule

`default_nettype wire
